// ----- design/mhpq_pkg.sv -----
// Shared types, codes and field widths of the min-heap priority queue.
package mhpq_pkg;

   // Field widths of the request and response channels
   localparam int OPCODE_BITS = 2;
   localparam int KEY_IN_BITS = 32;
   localparam int SLOT_BITS   = 6;
   localparam int STATUS_BITS = 2;
   localparam int TOTAL_BITS  = 7;

   // Defaults of the top-level parameters
   localparam int DEF_CAPACITY = 64;
   localparam int DEF_KEY_BITS = 32;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_CHANGE = 2'd2,
      OP_NOP    = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STAT_DONE         = 2'd0,
      STAT_FULL         = 2'd1,
      STAT_NOT_OCCUPIED = 2'd2
   } status_type;

   typedef struct packed {
      status_type                    status;
      logic [TOTAL_BITS-1:0]         entry_total;
      logic signed [KEY_IN_BITS-1:0] smallest_key;
   } mhpq_result_type;

endpackage

// ----- design/mhpq_if.sv -----
// Request and response channel interfaces of the min-heap priority queue.
interface mhpq_req_if;
   import mhpq_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [OPCODE_BITS-1:0]        opcode;
   logic signed [KEY_IN_BITS-1:0] key_value;
   logic [SLOT_BITS-1:0]          slot;

   modport source (output valid, output opcode, output key_value, output slot, input ready);
   modport sink (input valid, input opcode, input key_value, input slot, output ready);
endinterface

interface mhpq_rsp_if;
   import mhpq_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [STATUS_BITS-1:0]        status;
   logic [TOTAL_BITS-1:0]         entry_total;
   logic signed [KEY_IN_BITS-1:0] smallest_key;

   modport source (output valid, output status, output entry_total, output smallest_key,
                   input ready);
   modport sink (input valid, input status, input entry_total, input smallest_key,
                 output ready);
endinterface

// ----- design/mhpq_store.sv -----
// Heap key memory: one write port, two read ports with registered read data.
module mhpq_store #(
   parameter int DEPTH = mhpq_pkg::DEF_CAPACITY,
   parameter int WIDTH = mhpq_pkg::DEF_KEY_BITS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_a_addr,
   input  logic [$clog2(DEPTH)-1:0] rd_b_addr,
   output logic [WIDTH-1:0]         rd_a_data_ff,
   output logic [WIDTH-1:0]         rd_b_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry, read two
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_data_ff <= mem[rd_a_addr];
      rd_b_data_ff <= mem[rd_b_addr];
   end

endmodule

// ----- design/mhpq_seq.sv -----
// Sift sequencer: decodes a request and walks the heap one level per compare.
module mhpq_seq #(
   parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY,
   parameter int KEY_BITS = mhpq_pkg::DEF_KEY_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   mhpq_req_if.sink                    req_ch,
   output logic                        wr_en,
   output logic [$clog2(CAPACITY)-1:0] wr_addr,
   output logic [KEY_BITS-1:0]         wr_data,
   output logic [$clog2(CAPACITY)-1:0] rd_a_addr,
   output logic [$clog2(CAPACITY)-1:0] rd_b_addr,
   input  logic [KEY_BITS-1:0]         rd_a_data,
   input  logic [KEY_BITS-1:0]         rd_b_data,
   output logic                        res_valid,
   output mhpq_pkg::mhpq_result_type   result,
   input  logic                        res_taken
);
   import mhpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = (CW > SLOT_BITS) ? CW : SLOT_BITS;
   localparam int LW = AW + 2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD_LAST,
      S_LOAD_WAIT,
      S_UP_RD,
      S_UP_CMP,
      S_UP_END,
      S_DOWN_LOAD,
      S_DOWN_GET,
      S_DOWN_RD,
      S_DOWN_CMP,
      S_FINISH
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [AW-1:0]     home_ff, home_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] root_ff, root_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              reorder_ff, reorder_in;
   status_type        status_ff, status_in;

   logic [SW-1:0]     slot_w, cnt_w, cnt_m1;
   logic [AW-1:0]     slot_a, parent;
   logic [LW-1:0]     child_l, child_r, cnt_l;
   logic              l_ok, r_ok;
   logic [AW-1:0]     sel_pos;
   logic [KEY_BITS-1:0] sel_key;

   assign req_ch.ready = (state_ff == S_IDLE);

   // Index arithmetic around the current position
   assign slot_w  = SW'(req_ch.slot);
   assign cnt_w   = SW'(count_ff);
   assign cnt_m1  = SW'(count_ff - 1'b1);
   assign slot_a  = slot_w[AW-1:0];
   assign parent  = AW'((pos_ff - 1'b1) >> 1);
   assign child_l = {1'b0, pos_ff, 1'b1};
   assign child_r = LW'(child_l + 1'b1);
   assign cnt_l   = LW'(count_ff);
   assign l_ok    = (child_l < cnt_l);
   assign r_ok    = (child_r < cnt_l);

   // Pick the least of the held key and its two children, earlier wins a tie
   always_comb begin
      sel_pos = pos_ff;
      sel_key = key_ff;
      if (l_ok && ($signed(rd_a_data) < $signed(sel_key))) begin
         sel_pos = child_l[AW-1:0];
         sel_key = rd_a_data;
      end
      if (r_ok && ($signed(rd_b_data) < $signed(sel_key))) begin
         sel_pos = child_r[AW-1:0];
         sel_key = rd_b_data;
      end
   end

   // Sequence the sift steps
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      home_in    = home_ff;
      key_in     = key_ff;
      count_in   = count_ff;
      reorder_in = reorder_ff;
      status_in  = status_ff;
      rd_a_addr  = pos_ff;
      rd_b_addr  = pos_ff;
      wr_en      = 1'b0;
      wr_addr    = pos_ff;
      wr_data    = key_ff;
      res_valid  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               key_in    = KEY_BITS'($unsigned(req_ch.key_value));
               pos_in    = slot_a;
               home_in   = slot_a;
               status_in = STAT_DONE;
               unique case (opcode_type'(req_ch.opcode))
                  OP_INSERT: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        status_in = STAT_FULL;
                        state_in  = S_FINISH;
                     end else begin
                        pos_in     = count_ff[AW-1:0];
                        count_in   = CW'(count_ff + 1'b1);
                        reorder_in = 1'b0;
                        state_in   = S_UP_RD;
                     end
                  end
                  OP_DELETE: begin
                     if (slot_w >= cnt_w) begin
                        status_in = STAT_NOT_OCCUPIED;
                        state_in  = S_FINISH;
                     end else begin
                        count_in = CW'(count_ff - 1'b1);
                        if (slot_w < cnt_m1) begin
                           reorder_in = 1'b1;
                           state_in   = S_LOAD_LAST;
                        end else begin
                           state_in = S_FINISH;
                        end
                     end
                  end
                  OP_CHANGE: begin
                     if (slot_w >= cnt_w) begin
                        status_in = STAT_NOT_OCCUPIED;
                        state_in  = S_FINISH;
                     end else begin
                        reorder_in = 1'b1;
                        state_in   = S_UP_RD;
                     end
                  end
                  OP_NOP: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_LOAD_LAST: begin
            // fetch the last entry, which fills the deleted position
            rd_a_addr = count_ff[AW-1:0];
            state_in  = S_LOAD_WAIT;
         end
         S_LOAD_WAIT: begin
            key_in   = rd_a_data;
            state_in = S_UP_RD;
         end
         S_UP_RD: begin
            rd_a_addr = parent;
            state_in  = (pos_ff == '0) ? S_UP_END : S_UP_CMP;
         end
         S_UP_CMP: begin
            // move the parent down while the held key is smaller
            if ($signed(key_ff) < $signed(rd_a_data)) begin
               wr_en    = 1'b1;
               wr_data  = rd_a_data;
               pos_in   = parent;
               state_in = S_UP_RD;
            end else begin
               state_in = S_UP_END;
            end
         end
         S_UP_END: begin
            wr_en    = 1'b1;
            state_in = reorder_ff ? S_DOWN_LOAD : S_FINISH;
         end
         S_DOWN_LOAD: begin
            // sift down restarts at the original position
            rd_a_addr = home_ff;
            pos_in    = home_ff;
            state_in  = S_DOWN_GET;
         end
         S_DOWN_GET: begin
            key_in   = rd_a_data;
            state_in = S_DOWN_RD;
         end
         S_DOWN_RD: begin
            rd_a_addr = child_l[AW-1:0];
            rd_b_addr = child_r[AW-1:0];
            if (l_ok) begin
               state_in = S_DOWN_CMP;
            end else begin
               wr_en    = 1'b1;
               state_in = S_FINISH;
            end
         end
         S_DOWN_CMP: begin
            wr_en = 1'b1;
            if (sel_pos != pos_ff) begin
               wr_data  = sel_key;
               pos_in   = sel_pos;
               state_in = S_DOWN_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            res_valid = 1'b1;
            if (res_taken) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // track the root so the minimum needs no memory read
      root_in = root_ff;
      if (wr_en && (wr_addr == '0)) begin
         root_in = wr_data;
      end
   end

   assign result.status       = status_ff;
   assign result.entry_total  = TOTAL_BITS'(count_ff);
   assign result.smallest_key = (count_ff != '0) ? KEY_IN_BITS'(root_ff) : '0;

   // Hold state and working registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         reorder_ff <= 1'b0;
         status_ff  <= STAT_DONE;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         reorder_ff <= reorder_in;
         status_ff  <= status_in;
      end
      pos_ff  <= pos_in;
      home_ff <= home_in;
      key_ff  <= key_in;
      root_ff <= root_in;
   end

endmodule

// ----- design/min_heap_priority_queue_core.sv -----
// Binary min-heap priority queue: top level with request decode and response register.
//
// Usage: each request on req_ch carries an opcode (insert key_value, delete the entry
// at slot, change the entry at slot to key_value, or no-op). Each request yields one
// response on rsp_ch with the status, the number of keys held and the smallest key
// (zero when empty). A full heap refuses an insert; a slot at or past the count is
// flagged as not occupied; neither changes the heap.
// Order of work, accept to response valid: an insert raises its key level by level until
// it is no smaller than its parent or reaches the root; a change sifts up, then sifts
// down from its slot; a delete that moves the last entry first fetches it into the
// deleted position and then sifts as a change does. A refused request, a no-op or a
// delete of the last entry goes straight to the response. Throughput: one request at
// a time; the shared key compare and the single write port of the key memory handle
// one heap level at a time.
// Reset clears the count and the sequencer; the key memory is not cleared, since only
// occupied entries are read. A stalled receiver holds the response in its register;
// the next request is still taken and processed, and waits only to hand over its own.
module min_heap_priority_queue_core #(
   parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY,
   parameter int KEY_BITS = mhpq_pkg::DEF_KEY_BITS
) (
   input  logic       clock,
   input  logic       reset,
   mhpq_req_if.sink   req_ch,
   mhpq_rsp_if.source rsp_ch
);
   import mhpq_pkg::*;

   localparam int AW = $clog2(CAPACITY);

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [KEY_BITS-1:0] wr_data;
   logic [AW-1:0]       rd_a_addr, rd_b_addr;
   logic [KEY_BITS-1:0] rd_a_data, rd_b_data;
   logic                res_valid, res_taken;
   mhpq_result_type     result;

   logic                rsp_valid_ff, rsp_valid_in;
   mhpq_result_type     rsp_data_ff, rsp_data_in;

   mhpq_store #(
      .DEPTH (CAPACITY),
      .WIDTH (KEY_BITS)
   ) u_store (
      .clock        (clock),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .rd_a_addr    (rd_a_addr),
      .rd_b_addr    (rd_b_addr),
      .rd_a_data_ff (rd_a_data),
      .rd_b_data_ff (rd_b_data)
   );

   mhpq_seq #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data),
      .res_valid (res_valid),
      .result    (result),
      .res_taken (res_taken)
   );

   // Load the response register when it is empty or being drained
   assign res_taken = res_valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_taken) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_data_ff.status;
   assign rsp_ch.entry_total  = rsp_data_ff.entry_total;
   assign rsp_ch.smallest_key = rsp_data_ff.smallest_key;

endmodule

// ----- design/mhpq_checker.sv -----
// Port-level checks of the min-heap priority queue, bound to the top level.
module mhpq_checker #(
   parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic [mhpq_pkg::STATUS_BITS-1:0]       rsp_status,
   input logic [mhpq_pkg::TOTAL_BITS-1:0]        rsp_entry_total,
   input logic signed [mhpq_pkg::KEY_IN_BITS-1:0] rsp_smallest_key
);
   import mhpq_pkg::*;

   // A refused insert reports a full heap
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_FULL) |-> rsp_entry_total == TOTAL_BITS'(CAPACITY))
      else $error("refused insert without a full count");

   // An empty heap reports a zero minimum
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_entry_total == '0) |-> rsp_smallest_key == '0)
      else $error("empty heap with nonzero minimum");

   // A request keeps the sequencer busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken on two consecutive cycles");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_total) && $stable(rsp_smallest_key))
      else $error("stalled response changed");

endmodule

bind min_heap_priority_queue_core mhpq_checker #(
   .CAPACITY (CAPACITY)
) u_mhpq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_status       (rsp_ch.status),
   .rsp_entry_total  (rsp_ch.entry_total),
   .rsp_smallest_key (rsp_ch.smallest_key)
);

// ----- dv/mhpq_checker.sv -----
// Response checker: mirrors the heap from accepted requests and compares each response.
`timescale 1ns / 100ps

module mhpq_scoreboard #(
   parameter int CAPACITY = mhpq_pkg::DEF_CAPACITY
) (
   input  logic clock,
   input  logic reset,
   mhpq_req_if  req_ch,
   mhpq_rsp_if  rsp_ch,
   output int   error_count,
   output int   pending_count,
   output int   response_count,
   output int   full_refusals,
   output int   slot_refusals
);
   import mhpq_pkg::*;

   // Shadow copy of the heap array and its occupancy
   logic signed [KEY_IN_BITS-1:0] heap_keys [CAPACITY];
   int                            heap_count;

   // Responses still owed by the block, oldest first
   mhpq_result_type outcome_queue [$];

   function automatic void swap_keys(int a, int b);
      logic signed [KEY_IN_BITS-1:0] held_key;
      held_key     = heap_keys[a];
      heap_keys[a] = heap_keys[b];
      heap_keys[b] = held_key;
   endfunction

   // Raise a key while it is smaller than its parent
   function automatic void sift_up(int pos);
      int up;
      while (pos > 0) begin
         up = (pos - 1) / 2;
         if (heap_keys[pos] >= heap_keys[up]) break;
         swap_keys(pos, up);
         pos = up;
      end
   endfunction

   // Lower a key while a child is smaller, taking the smaller child
   function automatic void sift_down(int pos);
      int lchild;
      int rchild;
      int least;
      while (pos < heap_count) begin
         lchild = 2 * pos + 1;
         rchild = 2 * pos + 2;
         least  = pos;
         if (lchild < heap_count && heap_keys[lchild] < heap_keys[least]) least = lchild;
         if (rchild < heap_count && heap_keys[rchild] < heap_keys[least]) least = rchild;
         if (least == pos) break;
         swap_keys(pos, least);
         pos = least;
      end
   endfunction

   // Apply one request to the shadow heap and return the response it must produce
   function automatic mhpq_result_type heap_op_outcome(opcode_type op,
                                                       logic signed [KEY_IN_BITS-1:0] key,
                                                       int pos);
      mhpq_result_type res;
      res.status = STAT_DONE;
      case (op)
         OP_INSERT: begin
            if (heap_count >= CAPACITY) begin
               res.status = STAT_FULL;
            end else begin
               heap_keys[heap_count] = key;
               heap_count++;
               sift_up(heap_count - 1);
            end
         end
         OP_DELETE, OP_CHANGE: begin
            if (pos >= heap_count) begin
               res.status = STAT_NOT_OCCUPIED;
            end else if (op == OP_DELETE) begin
               // Move the last entry into the hole unless the hole is the last entry
               heap_count--;
               if (pos < heap_count) begin
                  heap_keys[pos] = heap_keys[heap_count];
                  sift_up(pos);
                  sift_down(pos);
               end
            end else begin
               heap_keys[pos] = key;
               sift_up(pos);
               sift_down(pos);
            end
         end
         default: ;
      endcase
      res.entry_total  = TOTAL_BITS'(heap_count);
      res.smallest_key = (heap_count > 0) ? heap_keys[0] : '0;
      return res;
   endfunction

   task automatic flag_mismatch(string detail);
      $display("%0t ns  MISMATCH  %s", $time, detail);
      error_count++;
   endtask

   // Compare responses first, then record the request taken on the same edge
   always @(posedge clock) begin
      mhpq_result_type awaited;
      if (reset) begin
         heap_count = 0;
         outcome_queue.delete();
         error_count    = 0;
         response_count = 0;
         full_refusals  = 0;
         slot_refusals  = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            response_count++;
            if (outcome_queue.size() == 0) begin
               flag_mismatch($sformatf("response %0d arrived with no request outstanding",
                                       response_count));
            end else begin
               awaited = outcome_queue.pop_front();
               if (rsp_ch.status !== awaited.status)
                  flag_mismatch($sformatf("response %0d status: expected %0d, got %0d",
                                          response_count, awaited.status, rsp_ch.status));
               if (rsp_ch.entry_total !== awaited.entry_total)
                  flag_mismatch($sformatf("response %0d entry_total: expected %0d, got %0d",
                                          response_count, awaited.entry_total,
                                          rsp_ch.entry_total));
               if (rsp_ch.smallest_key !== awaited.smallest_key)
                  flag_mismatch($sformatf("response %0d smallest_key: expected %0d, got %0d",
                                          response_count, awaited.smallest_key,
                                          rsp_ch.smallest_key));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            awaited = heap_op_outcome(opcode_type'(req_ch.opcode), req_ch.key_value,
                                      int'(req_ch.slot));
            if (awaited.status == STAT_FULL) full_refusals++;
            if (awaited.status == STAT_NOT_OCCUPIED) slot_refusals++;
            outcome_queue.push_back(awaited);
         end
      end
      pending_count = outcome_queue.size();
   end

endmodule

// ----- dv/tb.sv -----
// Testbench top: clock, reset, request and response drivers, and the final verdict.
`timescale 1ns / 100ps

module tb;
   import mhpq_pkg::*;

   localparam int     CAPACITY     = DEF_CAPACITY;
   localparam int     ITEM_TARGET  = 950;
   localparam int     HOLD_CYCLES  = 300;
   localparam int     DRAIN_CYCLES = 40;
   localparam longint CYCLE_LIMIT  = 400000;

   localparam logic signed [KEY_IN_BITS-1:0] KEY_MAX = 32'sh7fffffff;
   localparam logic signed [KEY_IN_BITS-1:0] KEY_MIN = 32'sh80000000;

   logic   clock;
   logic   reset;
   longint cycle_count = 0;

   mhpq_req_if req_ch ();
   mhpq_rsp_if rsp_ch ();

   int error_count;
   int pending_count;
   int response_count;
   int full_refusals;
   int slot_refusals;

   // Stimulus-side view of occupancy, used to aim slots, end the fill and drain phases and track the peak
   int held       = 0;
   int peak_held  = 0;
   int sent_count = 0;

   bit sender_idle   = 1'b1;
   bit receiver_idle = 1'b1;
   bit hold_request  = 1'b0;

   min_heap_priority_queue_core #(
      .CAPACITY(CAPACITY),
      .KEY_BITS(DEF_KEY_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   mhpq_scoreboard #(
      .CAPACITY(CAPACITY)
   ) heap_check (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .error_count   (error_count),
      .pending_count (pending_count),
      .response_count(response_count),
      .full_refusals (full_refusals),
      .slot_refusals (slot_refusals)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, pending_count);
         $display("min_heap_priority_queue_core regression: fail");
         $finish;
      end
   end

   // Mix full-range keys, a narrow band that forces ties, and values at the extremes
   function automatic logic signed [KEY_IN_BITS-1:0] rand_key();
      logic signed [KEY_IN_BITS-1:0] k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: k = $urandom;
         5, 6, 7: begin
            k = $urandom_range(0, 16);
            k = k - 8;
         end
         8: k = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
         default: k = ($urandom_range(0, 1) ? KEY_MAX : KEY_MIN) ^ $urandom_range(0, 7);
      endcase
      return k;
   endfunction

   // Mostly occupied positions, sometimes any position
   function automatic logic [SLOT_BITS-1:0] rand_slot();
      if (held > 0 && $urandom_range(0, 9) < 8) return SLOT_BITS'($urandom_range(0, held - 1));
      return SLOT_BITS'($urandom_range(0, 63));
   endfunction

   function automatic opcode_type pick_op(int insert_pct, int delete_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < insert_pct) return OP_INSERT;
      if (r < insert_pct + delete_pct) return OP_DELETE;
      if (r < 97) return OP_CHANGE;
      return OP_NOP;
   endfunction

   // Offer one request, after a random gap when sender_idle is set, and hold it until accepted
   task automatic offer_request(opcode_type op, logic signed [KEY_IN_BITS-1:0] key,
                                logic [SLOT_BITS-1:0] slot);
      int gap;
      gap = sender_idle ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.opcode    = op;
      req_ch.key_value = key;
      req_ch.slot      = slot;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      sent_count++;
      case (op)
         OP_INSERT: if (held < CAPACITY) held++;
         OP_DELETE: if (slot < held) held--;
         default: ;
      endcase
      if (held > peak_held) peak_held = held;
   endtask

   task automatic run_mixed(int items, int insert_pct, int delete_pct);
      repeat (items) offer_request(pick_op(insert_pct, delete_pct), rand_key(), rand_slot());
   endtask

   // Response side: random ready gaps while receiver_idle is set, plus one long hold-off on request
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         gap = receiver_idle ? $urandom_range(0, 15) : 0;
         if (gap > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.opcode    = OP_INSERT;
      req_ch.key_value = '0;
      req_ch.slot      = '0;
      reset            = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty heap, extreme keys, ties, both sift directions, edge slots
      offer_request(OP_DELETE, 32'sd0, 6'd0);
      offer_request(OP_CHANGE, 32'sd5, 6'd0);
      offer_request(OP_NOP, KEY_MAX, 6'd63);
      offer_request(OP_INSERT, KEY_MAX, 6'd0);
      offer_request(OP_INSERT, KEY_MIN, 6'd63);
      offer_request(OP_INSERT, 32'sd0, 6'd0);
      offer_request(OP_INSERT, -32'sd1, 6'd0);
      offer_request(OP_INSERT, 32'sd1, 6'd0);
      offer_request(OP_INSERT, -32'sd1, 6'd0);
      offer_request(OP_CHANGE, KEY_MAX, 6'd0);
      offer_request(OP_CHANGE, KEY_MIN, SLOT_BITS'(held - 1));
      offer_request(OP_CHANGE, 32'sd0, 6'd1);
      offer_request(OP_DELETE, 32'sd0, SLOT_BITS'(held));
      offer_request(OP_DELETE, KEY_MIN, 6'd63);
      offer_request(OP_CHANGE, KEY_MIN, 6'd63);
      offer_request(OP_DELETE, 32'sd0, SLOT_BITS'(held - 1));
      offer_request(OP_DELETE, 32'sd0, 6'd0);
      offer_request(OP_DELETE, 32'sd0, 6'd1);
      offer_request(OP_NOP, -32'sd1, 6'd0);
      offer_request(OP_INSERT, KEY_MIN, 6'd0);
      offer_request(OP_INSERT, KEY_MIN, 6'd0);

      // Random mix, growing the heap, idling on both sides
      run_mixed(250, 55, 25);

      // Fill to capacity back to back, then work at the full boundary
      sender_idle = 1'b0;
      while (held < CAPACITY) offer_request(OP_INSERT, rand_key(), SLOT_BITS'($urandom));
      offer_request(OP_INSERT, KEY_MAX, 6'd0);
      offer_request(OP_INSERT, KEY_MIN, 6'd0);
      offer_request(OP_CHANGE, KEY_MIN, 6'd63);
      offer_request(OP_DELETE, 32'sd0, 6'd63);
      offer_request(OP_INSERT, rand_key(), 6'd0);
      offer_request(OP_DELETE, 32'sd0, 6'd0);
      offer_request(OP_INSERT, KEY_MIN, 6'd0);
      offer_request(OP_CHANGE, KEY_MAX, 6'd0);
      offer_request(OP_INSERT, rand_key(), 6'd0);

      // Stay near full with the receiver always ready
      sender_idle   = 1'b1;
      receiver_idle = 1'b0;
      run_mixed(80, 50, 30);

      // Drain to empty, with changes mixed in, then poke the empty heap
      receiver_idle = 1'b1;
      while (held > 0) begin
         if ($urandom_range(0, 4) == 0) offer_request(OP_CHANGE, rand_key(), rand_slot());
         else offer_request(OP_DELETE, rand_key(), rand_slot());
      end
      offer_request(OP_DELETE, rand_key(), 6'd0);
      offer_request(OP_CHANGE, rand_key(), 6'd0);

      // Back-to-back requests against a long receiver hold-off
      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      hold_request  = 1'b1;
      run_mixed(200, 50, 30);

      // Random mix with idling until the request budget is spent
      sender_idle   = 1'b1;
      receiver_idle = 1'b1;
      while (sent_count < ITEM_TARGET) run_mixed(1, 45, 35);
      req_ch.valid = 1'b0;

      // Let every response drain, then allow for stragglers
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests and %0d checked responses; peak occupancy %0d of %0d.",
               sent_count, response_count, peak_held, CAPACITY);
      $display("Refused %0d inserts on a full heap and %0d requests naming an empty slot.",
               full_refusals, slot_refusals);
      if (error_count == 0 && pending_count == 0) begin
         $display("min_heap_priority_queue_core regression: pass");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", error_count, pending_count);
         $display("min_heap_priority_queue_core regression: fail");
      end
      $finish;
   end

endmodule
